// ----- design/bpfa_pkg.sv -----
// Shared constants, types and helpers for the bitmap page frame allocator.
package bpfa_pkg;

    localparam int NUM_FRAMES   = 32768;
    localparam int WORD_BITS    = 32;
    localparam int FRAME_BYTES  = 4096;
    localparam int LARGE_FRAMES = 1024;

    localparam int MAP_WORDS  = NUM_FRAMES / WORD_BITS;
    localparam int WADDR_W    = $clog2(MAP_WORDS);
    localparam int PTR_W      = WADDR_W + 1;
    localparam int FRAME_W    = $clog2(NUM_FRAMES);
    localparam int FEND_W     = FRAME_W + 1;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int PAGE_SHIFT = $clog2(FRAME_BYTES);
    localparam int LARGE_SH   = $clog2(LARGE_FRAMES);
    localparam int RUN_W      = FEND_W + 1;
    localparam int ADDR_W     = 32;
    localparam int LEN_W      = 32;
    localparam int FREE_W     = 16;
    localparam int MB_W       = 16;
    localparam int KIND_W     = 3;
    localparam int WIDE_W     = LEN_W + 2;

    localparam logic [KIND_W-1:0] KIND_ALLOC_ONE   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ALLOC_RUN   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ALLOC_LARGE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FREE_RUN    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MARK_FREE   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_MARK_USED   = 3'd5;

    localparam logic STATUS_DONE     = 1'b0;
    localparam logic STATUS_NO_SPACE = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_SRCH_RD, ST_SRCH_EVAL, ST_SRCH_BIT,
        ST_GRANT, ST_FAIL, ST_FIX0, ST_RMW_RD, ST_RMW_CALC, ST_RMW_WR, ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_CLEAR, OP_LOAD, OP_SRCH_RD, OP_SRCH_EVAL, OP_SRCH_BIT,
        OP_GRANT, OP_FAIL, OP_FIX0, OP_RMW_RD, OP_RMW_CALC, OP_RMW_WR
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic              clear_last;
        logic [KIND_W-1:0] kind;
        logic              pre_ok;
        logic              limit_zero;
        logic              word_free;
        logic              word_taken;
        logic              found_word;
        logic              found_bit;
        logic              bit_last;
        logic              last_word;
        logic              range_skip;
        logic              range_last;
        logic              fix_done;
    } dp_stat_t;

    function automatic logic [BIT_W:0] popcount(input logic [WORD_BITS-1:0] v);
        logic [BIT_W:0] acc;
        acc = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            acc = acc + {{BIT_W{1'b0}}, v[i]};
        end
        return acc;
    endfunction

endpackage

// ----- design/bpfa_ctrl.sv -----
// Controller state machine: sequences clear, search and read-modify-write passes.
module bpfa_ctrl import bpfa_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     out_free,
    output logic     out_load,
    input  dp_stat_t st,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (st.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_valid) state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                if (st.kind == KIND_ALLOC_ONE || st.kind == KIND_ALLOC_RUN ||
                    st.kind == KIND_ALLOC_LARGE) begin
                    if (!st.pre_ok || st.limit_zero) state_next = ST_FAIL;
                    else state_next = ST_SRCH_RD;
                end else if (st.kind == KIND_FREE_RUN || st.kind == KIND_MARK_USED) begin
                    state_next = st.range_skip ? ST_DONE : ST_RMW_RD;
                end else if (st.kind == KIND_MARK_FREE) begin
                    state_next = st.range_skip ? ST_FIX0 : ST_RMW_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SRCH_RD:   state_next = ST_SRCH_EVAL;
            ST_SRCH_EVAL: begin
                if (st.found_word) state_next = ST_GRANT;
                else if (!st.word_free && !st.word_taken) state_next = ST_SRCH_BIT;
                else if (st.last_word) state_next = ST_FAIL;
                else state_next = ST_SRCH_RD;
            end
            ST_SRCH_BIT: begin
                if (st.found_bit) state_next = ST_GRANT;
                else if (st.bit_last) state_next = st.last_word ? ST_FAIL : ST_SRCH_RD;
            end
            ST_GRANT:    state_next = ST_RMW_RD;
            ST_FAIL:     state_next = ST_DONE;
            ST_FIX0:     state_next = ST_RMW_RD;
            ST_RMW_RD:   state_next = ST_RMW_CALC;
            ST_RMW_CALC: state_next = ST_RMW_WR;
            ST_RMW_WR: begin
                if (!st.range_last) state_next = ST_RMW_RD;
                else if (st.kind == KIND_MARK_FREE && !st.fix_done) state_next = ST_FIX0;
                else state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        cmd.op   = OP_NONE;
        in_ready = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_CLEAR:     cmd.op = OP_CLEAR;
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) cmd.op = OP_LOAD;
            end
            ST_DISPATCH:  cmd.op = OP_NONE;
            ST_SRCH_RD:   cmd.op = OP_SRCH_RD;
            ST_SRCH_EVAL: cmd.op = OP_SRCH_EVAL;
            ST_SRCH_BIT:  cmd.op = OP_SRCH_BIT;
            ST_GRANT:     cmd.op = OP_GRANT;
            ST_FAIL:      cmd.op = OP_FAIL;
            ST_FIX0:      cmd.op = OP_FIX0;
            ST_RMW_RD:    cmd.op = OP_RMW_RD;
            ST_RMW_CALC:  cmd.op = OP_RMW_CALC;
            ST_RMW_WR:    cmd.op = OP_RMW_WR;
            ST_DONE:      out_load = out_free;
            default:      cmd.op = OP_NONE;
        endcase
    end

endmodule

// ----- design/bpfa_dp.sv -----
// Datapath: frame bitmap memory, search counters, range masks and free counter.
module bpfa_dp import bpfa_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [MB_W-1:0]   cfg_wdata,
    input  logic [KIND_W-1:0] in_kind,
    input  logic [ADDR_W-1:0] in_address,
    input  logic [LEN_W-1:0]  in_length,
    input  dp_cmd_t           cmd,
    output dp_stat_t          st,
    output logic              res_status,
    output logic [ADDR_W-1:0] res_granted,
    output logic [FREE_W-1:0] res_free
);

    localparam logic [WORD_BITS-1:0] ALL_ONES = '1;

    logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;

    logic [MB_W-1:0]      managed_reg;
    logic [FREE_W-1:0]    free_reg, free_next;
    logic [PTR_W-1:0]     ptr_reg, ptr_next;
    logic [KIND_W-1:0]    kind_reg;
    logic                 pre_ok_reg;
    logic [PTR_W-1:0]     limit_reg;
    logic [RUN_W-1:0]     need_reg;
    logic [RUN_W-1:0]     cnt_reg, cnt_next;
    logic [FRAME_W-1:0]   first_reg, first_next;
    logic [FRAME_W-1:0]   start_reg;
    logic [BIT_W-1:0]     bit_reg;
    logic [WORD_BITS-1:0] word_reg;
    logic [FRAME_W-1:0]   rng_first_reg;
    logic [FEND_W-1:0]    rng_end_reg;
    logic                 take_reg;
    logic                 skip_reg;
    logic                 fix_reg;
    logic [WORD_BITS-1:0] new_word_reg;
    logic [WORD_BITS-1:0] flip_reg;
    logic                 status_reg;
    logic [ADDR_W-1:0]    granted_reg;

    // search evaluation
    logic [FRAME_W-1:0]   base;
    logic [WORD_BITS-1:0] fm;
    logic                 all_free, all_taken;
    logic [RUN_W-1:0]     cnt_p32, cnt_p1;
    logic                 found_word, found_bit, bitv;
    logic [FRAME_W-1:0]   bit_frame;

    // range masks
    logic [BIT_W-1:0]     lo;
    logic [FEND_W-1:0]    end_rel;
    logic [WORD_BITS-1:0] mask;

    // request decode
    logic [ADDR_W-PAGE_SHIFT-1:0] f0;
    logic [WIDE_W-1:0]    reg_sum, num, end_full;
    logic                 ld_skip;
    logic [FEND_W-1:0]    ld_end;
    logic                 ld_pre_ok;
    logic [RUN_W-1:0]     ld_need;
    logic [PTR_W-1:0]     ld_limit;

    // grant setup
    logic [FRAME_W-1:0]   g_first;
    logic [FEND_W-1:0]    g_end;

    always_comb begin
        base      = {ptr_reg[WADDR_W-1:0], {BIT_W{1'b0}}};
        fm        = ~rd_data_reg;
        if (ptr_reg == '0) fm[0] = 1'b0;
        all_free  = (fm == ALL_ONES);
        all_taken = (fm == '0);
        cnt_p32   = cnt_reg + RUN_W'(WORD_BITS);
        cnt_p1    = cnt_reg + RUN_W'(1);
        found_word = all_free && (cnt_p32 >= need_reg);
        bitv      = word_reg[bit_reg];
        found_bit = bitv && (cnt_p1 == need_reg);
        bit_frame = base | FRAME_W'(bit_reg);
    end

    always_comb begin
        lo = (ptr_reg[WADDR_W-1:0] == rng_first_reg[FRAME_W-1:BIT_W]) ?
             rng_first_reg[BIT_W-1:0] : '0;
        end_rel = rng_end_reg - {1'b0, ptr_reg[WADDR_W-1:0], {BIT_W{1'b0}}};
        mask = ALL_ONES << lo;
        if (end_rel < FEND_W'(WORD_BITS)) begin
            mask = mask & ~(ALL_ONES << end_rel[BIT_W-1:0]);
        end
    end

    always_comb begin
        f0       = in_address[ADDR_W-1:PAGE_SHIFT];
        reg_sum  = WIDE_W'(in_length) + WIDE_W'(in_address[PAGE_SHIFT-1:0])
                 + WIDE_W'(FRAME_BYTES - 1);
        num      = (in_kind == KIND_FREE_RUN) ? WIDE_W'(in_length)
                                              : (reg_sum >> PAGE_SHIFT);
        end_full = WIDE_W'(f0) + num;
        ld_skip  = (WIDE_W'(f0) >= WIDE_W'(NUM_FRAMES)) || (num == '0);
        ld_end   = (end_full >= WIDE_W'(NUM_FRAMES)) ? FEND_W'(NUM_FRAMES)
                                                     : end_full[FEND_W-1:0];
        ld_pre_ok = 1'b0;
        ld_need   = RUN_W'(1);
        if (in_kind == KIND_ALLOC_ONE) begin
            ld_pre_ok = (free_reg != '0);
        end else if (in_kind == KIND_ALLOC_RUN) begin
            ld_pre_ok = (in_length != '0) && (LEN_W'(free_reg) >= in_length);
            ld_need   = in_length[RUN_W-1:0];
        end else if (in_kind == KIND_ALLOC_LARGE) begin
            ld_pre_ok = (free_reg >= FREE_W'(2 * LARGE_FRAMES));
            ld_need   = RUN_W'(2 * LARGE_FRAMES);
        end
        ld_limit = (managed_reg >= MB_W'(NUM_FRAMES)) ? PTR_W'(MAP_WORDS)
                                                       : PTR_W'(managed_reg >> BIT_W);
    end

    always_comb begin
        g_first = start_reg;
        g_end   = FEND_W'(start_reg) + FEND_W'(1);
        if (kind_reg == KIND_ALLOC_RUN) begin
            g_end = FEND_W'(start_reg) + need_reg[FEND_W-1:0];
        end else if (kind_reg == KIND_ALLOC_LARGE) begin
            g_first = {start_reg[FRAME_W-1:LARGE_SH] + 1'b1, {LARGE_SH{1'b0}}};
            g_end   = FEND_W'(g_first) + FEND_W'(LARGE_FRAMES);
        end
    end

    always_comb begin
        st.clear_last = (ptr_reg == PTR_W'(MAP_WORDS - 1));
        st.kind       = kind_reg;
        st.pre_ok     = pre_ok_reg;
        st.limit_zero = (limit_reg == '0);
        st.word_free  = all_free;
        st.word_taken = all_taken;
        st.found_word = found_word;
        st.found_bit  = found_bit;
        st.bit_last   = (bit_reg == '1);
        st.last_word  = ((ptr_reg + PTR_W'(1)) == limit_reg);
        st.range_skip = skip_reg;
        st.range_last = (ptr_reg == PTR_W'((rng_end_reg - FEND_W'(1)) >> BIT_W));
        st.fix_done   = fix_reg;
    end

    always_comb begin
        ptr_next   = ptr_reg;
        cnt_next   = cnt_reg;
        first_next = first_reg;
        free_next  = free_reg;
        unique case (cmd.op)
            OP_CLEAR:  ptr_next = ptr_reg + PTR_W'(1);
            OP_LOAD: begin
                // searches start at word 0, range passes at the first frame's word
                if (in_kind == KIND_ALLOC_ONE || in_kind == KIND_ALLOC_RUN ||
                    in_kind == KIND_ALLOC_LARGE) begin
                    ptr_next = '0;
                end else begin
                    ptr_next = PTR_W'(f0[FRAME_W-1:BIT_W]);
                end
                cnt_next = '0;
            end
            OP_SRCH_EVAL: begin
                if (all_free && !found_word) begin
                    if (cnt_reg == '0) first_next = base;
                    cnt_next = cnt_p32;
                    ptr_next = ptr_reg + PTR_W'(1);
                end else if (all_taken) begin
                    cnt_next = '0;
                    ptr_next = ptr_reg + PTR_W'(1);
                end
            end
            OP_SRCH_BIT: begin
                if (bitv) begin
                    if (cnt_reg == '0) first_next = bit_frame;
                    cnt_next = cnt_p1;
                end else begin
                    cnt_next = '0;
                end
                if (!found_bit && bit_reg == '1) ptr_next = ptr_reg + PTR_W'(1);
            end
            OP_GRANT:  ptr_next = PTR_W'(g_first[FRAME_W-1:BIT_W]);
            OP_FIX0:   ptr_next = '0;
            OP_RMW_WR: begin
                ptr_next = ptr_reg + PTR_W'(1);
                if (take_reg) free_next = free_reg - FREE_W'(popcount(flip_reg));
                else free_next = free_reg + FREE_W'(popcount(flip_reg));
            end
            default: ptr_next = ptr_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg     <= '0;
            free_reg    <= '0;
            managed_reg <= '0;
        end else begin
            ptr_reg  <= ptr_next;
            free_reg <= free_next;
            if (cfg_we) managed_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        first_reg <= first_next;
        unique case (cmd.op)
            OP_LOAD: begin
                kind_reg      <= in_kind;
                pre_ok_reg    <= ld_pre_ok;
                need_reg      <= ld_need;
                limit_reg     <= ld_limit;
                skip_reg      <= ld_skip;
                rng_first_reg <= f0[FRAME_W-1:0];
                rng_end_reg   <= ld_end;
                take_reg      <= (in_kind == KIND_MARK_USED);
                fix_reg       <= 1'b0;
                status_reg    <= STATUS_DONE;
                granted_reg   <= '0;
            end
            OP_SRCH_EVAL: begin
                word_reg <= fm;
                bit_reg  <= '0;
                if (found_word) start_reg <= (cnt_reg == '0) ? base : first_reg;
            end
            OP_SRCH_BIT: begin
                bit_reg <= bit_reg + BIT_W'(1);
                if (found_bit) start_reg <= (cnt_reg == '0) ? bit_frame : first_reg;
            end
            OP_GRANT: begin
                rng_first_reg <= g_first;
                rng_end_reg   <= g_end;
                take_reg      <= 1'b1;
                granted_reg   <= ADDR_W'({g_first, {PAGE_SHIFT{1'b0}}});
            end
            OP_FAIL: begin
                status_reg  <= STATUS_NO_SPACE;
                granted_reg <= '0;
            end
            OP_FIX0: begin
                rng_first_reg <= '0;
                rng_end_reg   <= FEND_W'(1);
                take_reg      <= 1'b1;
                fix_reg       <= 1'b1;
            end
            OP_RMW_CALC: begin
                new_word_reg <= take_reg ? (rd_data_reg | mask) : (rd_data_reg & ~mask);
                flip_reg     <= take_reg ? (~rd_data_reg & mask) : (rd_data_reg & mask);
            end
            default: word_reg <= word_reg;
        endcase
    end

    // bitmap memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_CLEAR) begin
            map_mem[ptr_reg[WADDR_W-1:0]] <= ALL_ONES;
        end else if (cmd.op == OP_RMW_WR) begin
            map_mem[ptr_reg[WADDR_W-1:0]] <= new_word_reg;
        end
        if (cmd.op == OP_SRCH_RD || cmd.op == OP_RMW_RD) begin
            rd_data_reg <= map_mem[ptr_reg[WADDR_W-1:0]];
        end
    end

    assign res_status  = status_reg;
    assign res_granted = granted_reg;
    assign res_free    = free_reg;

endmodule

// ----- design/bitmap_page_frame_allocator_top.sv -----
// Top level of the bitmap page frame allocator: stream ports and output register.
//
// Usage:
//   s_ channel carries one request transaction: s_tuser holds the request kind
//   (alloc one, alloc run, alloc large aligned, free run, mark free region,
//   mark used region), s_tdata holds address and length.
//   m_ channel returns exactly one result transaction per request: status,
//   granted byte address and the free frame count after the request.
//   cfg_we/cfg_wdata write managed_blocks, the number of frames searched;
//   write it only while no request is in flight.
// Sequencing: one request at a time. An allocation walks the map one 32-bit
//   word at a time, reading then evaluating it, and scans each partly taken
//   word bit by bit; it then marks its run with a read-modify-write (read,
//   calculate, write) per word. Frees and region marks do a read-modify-write
//   per word touched; mark free then retakes frame 0.
// Reset: aresetn low clears control state; afterwards a clearing pass writes
//   every word of the map to taken, with s_tready held low meanwhile.
//   Configuration writes are taken at any time.
// Stall: the result sits in an output register; the next request may be
//   accepted while it waits, and that request's result waits for m_tready.
module bitmap_page_frame_allocator_top import bpfa_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] address, [63:32] length
    input  logic [2:0]  s_tuser,   // [2:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // [0] status, [32:1] granted_address, [48:33] free_count
);

    dp_cmd_t           cmd;
    dp_stat_t          st;
    logic              out_load;
    logic              out_free;
    logic              res_status;
    logic [ADDR_W-1:0] res_granted;
    logic [FREE_W-1:0] res_free;

    logic              m_tvalid_reg;
    logic [55:0]       m_tdata_reg;

    // output slot is free when empty or being drained this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    bpfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .out_load (out_load),
        .st       (st),
        .cmd      (cmd)
    );

    bpfa_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_kind     (s_tuser),
        .in_address  (s_tdata[31:0]),
        .in_length   (s_tdata[63:32]),
        .cmd         (cmd),
        .st          (st),
        .res_status  (res_status),
        .res_granted (res_granted),
        .res_free    (res_free)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {7'd0, res_free, res_granted, res_status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- design/bpfa_checker.sv -----
// Port-level checker for the allocator top, attached by bind.
module bpfa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    // clearing pass follows reset: no request taken right after it
    a_no_accept_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("request port ready right after reset");

    // one request at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken back to back");

    // a failed request grants nothing
    a_fail_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[32:1] == 32'd0))
        else $error("no-space result carries an address");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind bitmap_page_frame_allocator_top bpfa_checker u_bpfa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/bpfa_result_checker.sv -----
// Scoreboard for the bitmap page frame allocator: predicts each result and compares it.
module bpfa_result_checker import bpfa_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic        status;
        logic [31:0] granted;
        logic [15:0] free_cnt;
    } alloc_result_t;

    bit [NUM_FRAMES-1:0] taken_map;
    int unsigned         free_frames;
    logic [MB_W-1:0]     managed_blocks;
    alloc_result_t       awaited_results[$];

    function automatic void take_page(longint unsigned f);
        if (f < NUM_FRAMES && !taken_map[f]) begin
            taken_map[f] = 1'b1;
            free_frames--;
        end
    endfunction

    function automatic void release_page(longint unsigned f);
        if (f < NUM_FRAMES && taken_map[f]) begin
            taken_map[f] = 1'b0;
            free_frames++;
        end
    endfunction

    function automatic void mark_pages(longint unsigned first, longint unsigned num, bit used);
        if (first < NUM_FRAMES) begin
            if (num > NUM_FRAMES - first) num = NUM_FRAMES - first;
            for (longint unsigned i = 0; i < num; i++) begin
                if (used) take_page(first + i);
                else release_page(first + i);
            end
        end
    endfunction

    // first fit over the searchable window; page 0 never qualifies
    function automatic bit first_fit(longint unsigned need, output int unsigned start);
        int unsigned lim;
        int unsigned run_start;
        longint unsigned run_len;
        lim = (managed_blocks > NUM_FRAMES) ? NUM_FRAMES : managed_blocks;
        lim = (lim / WORD_BITS) * WORD_BITS;
        run_start = 0;
        run_len = 0;
        start = 0;
        for (int unsigned f = 0; f < lim; f++) begin
            if (f != 0 && !taken_map[f]) begin
                if (run_len == 0) run_start = f;
                run_len++;
                if (run_len == need) begin
                    start = run_start;
                    return 1'b1;
                end
            end else begin
                run_len = 0;
            end
        end
        return 1'b0;
    endfunction

    function automatic alloc_result_t serve_request(logic [2:0] kind, logic [31:0] addr,
                                                    logic [31:0] len);
        alloc_result_t r;
        int unsigned start;
        longint unsigned base, span, aligned;
        r = '0;
        base = addr / FRAME_BYTES;
        span = (longint'(len) + (addr % FRAME_BYTES) + FRAME_BYTES - 1) / FRAME_BYTES;
        case (kind)
            KIND_ALLOC_ONE: begin
                if (free_frames != 0 && first_fit(1, start)) begin
                    take_page(start);
                    r.granted = start * FRAME_BYTES;
                end else r.status = STATUS_NO_SPACE;
            end
            KIND_ALLOC_RUN: begin
                if (len != 0 && free_frames >= len && first_fit(len, start)) begin
                    mark_pages(start, len, 1'b1);
                    r.granted = start * FRAME_BYTES;
                end else r.status = STATUS_NO_SPACE;
            end
            KIND_ALLOC_LARGE: begin
                if (free_frames >= 2 * LARGE_FRAMES && first_fit(2 * LARGE_FRAMES, start)) begin
                    aligned = (start / LARGE_FRAMES + 1) * LARGE_FRAMES;
                    mark_pages(aligned, LARGE_FRAMES, 1'b1);
                    r.granted = aligned * FRAME_BYTES;
                end else r.status = STATUS_NO_SPACE;
            end
            KIND_FREE_RUN:  mark_pages(base, len, 1'b0);
            KIND_MARK_FREE: begin
                mark_pages(base, span, 1'b0);
                take_page(0);
            end
            KIND_MARK_USED: mark_pages(base, span, 1'b1);
            default: ;
        endcase
        r.free_cnt = free_frames[15:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        alloc_result_t got, want;
        int bad;
        bad = 0;
        if (!aresetn) begin
            taken_map = '1;
            free_frames = 0;
            managed_blocks = '0;
            awaited_results.delete();
            errors <= 0;
        end else begin
            if (cfg_we) managed_blocks = cfg_wdata;
            if (s_tvalid && s_tready)
                awaited_results.push_back(serve_request(s_tuser, s_tdata[31:0], s_tdata[63:32]));
            if (m_tvalid && m_tready) begin
                got.status   = m_tdata[0];
                got.granted  = m_tdata[32:1];
                got.free_cnt = m_tdata[48:33];
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result status=%0d addr=%h free=%0d", $time,
                             got.status, got.granted, got.free_cnt);
                    bad++;
                end else begin
                    want = awaited_results.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d", $time, want.status,
                                 got.status);
                        bad++;
                    end
                    if (got.granted !== want.granted) begin
                        $display("%0t: granted_address expected %h actual %h", $time,
                                 want.granted, got.granted);
                        bad++;
                    end
                    if (got.free_cnt !== want.free_cnt) begin
                        $display("%0t: free_count expected %0d actual %0d", $time,
                                 want.free_cnt, got.free_cnt);
                        bad++;
                    end
                end
            end
            errors <= errors + bad;
        end
        pending <= awaited_results.size();
    end

endmodule

// ----- tb/bitmap_page_frame_allocator_top_test.sv -----
// Test top for the bitmap page frame allocator: stimulus, receiver stalls and verdict.
module bitmap_page_frame_allocator_top_test;
    import bpfa_pkg::*;

    // kinds with no defined meaning; the block must ignore them
    localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;
    localparam int IDLE_LIMIT = 200000;  // cycles without any transaction
    localparam int SQUEEZE_CYCLES = 4000;
    localparam int PHASE_ITEMS = 65;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;    // [31:0] address, [63:32] length
    logic [2:0]  s_tuser;    // [2:0] kind
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;    // [0] status, [32:1] granted_address, [48:33] free_count
    int          errors;
    int          pending;

    int  stall_mode;         // receiver pattern, picked per phase
    bit  squeeze_req;        // asks the receiver for one long hold-off
    bit  squeeze_done;
    int  squeeze_left;
    int  quiet_cycles;

    bitmap_page_frame_allocator_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    bpfa_result_checker scoreboard (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .errors(errors), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Receiver: one long hold-off on request, otherwise the phase's pattern.
    initial begin
        m_tready = 1'b0;
        squeeze_left = 0;
        squeeze_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (squeeze_left > 0) begin
                squeeze_left--;
                m_tready <= 1'b0;
            end else if (squeeze_req && !squeeze_done) begin
                squeeze_done = 1'b1;
                squeeze_left = SQUEEZE_CYCLES;
                m_tready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= $urandom_range(0, 1);
                    2: m_tready <= ($urandom_range(0, 4) == 0);
                    default: m_tready <= (($time / 12) % 3 != 0);
                endcase
            end
        end
    end

    // Watchdog: the run is hung if no transaction moves on either channel for too long.
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Offer one request and hold it until the block takes it, then maybe pause.
    task automatic send_request(logic [2:0] kind, logic [31:0] addr, logic [31:0] len);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {len, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // bursts: most of the time no gap, sometimes a short or long pause
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Register writes only once every awaited result has come back.
    task automatic set_managed_blocks(logic [15:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Byte address somewhere inside the map, at a random offset within its page.
    function automatic logic [31:0] map_address();
        return $urandom_range(0, NUM_FRAMES - 1) * FRAME_BYTES
               + $urandom_range(0, FRAME_BYTES - 1);
    endfunction

    // Random request mix; most requests are meaningful, a few are pure noise.
    task automatic send_random_request();
        int pick;
        logic [31:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            send_request(KIND_ALLOC_ONE, $urandom, $urandom);
        end else if (pick < 30) begin
            len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 40) :
                  ($urandom_range(0, 1) ? $urandom_range(41, 2500) : $urandom);
            send_request(KIND_ALLOC_RUN, $urandom, len);
        end else if (pick < 38) begin
            send_request(KIND_ALLOC_LARGE, $urandom, $urandom);
        end else if (pick < 55) begin
            len = $urandom_range(0, 4) ? $urandom_range(1, 300) : $urandom;
            send_request(KIND_FREE_RUN, map_address(), len);
        end else if (pick < 75) begin
            len = $urandom_range(0, 5) ? $urandom_range(0, 1 << 23) : $urandom;
            send_request(KIND_MARK_FREE, map_address(), len);
        end else if (pick < 92) begin
            send_request(KIND_MARK_USED, map_address(), $urandom_range(0, 1 << 20));
        end else if (pick < 97) begin
            send_request(KIND_W'(KIND_FREE_RUN + $urandom_range(0, 2)), $urandom, $urandom);
        end else begin
            send_request($urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B, $urandom, $urandom);
        end
    endtask

    initial begin
        logic [15:0] window_sizes[8];
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = KIND_ALLOC_ONE;
        stall_mode = 0;
        squeeze_req = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty window, everything taken after reset.
        send_request(KIND_ALLOC_ONE, 32'h0, 32'h0);
        send_request(KIND_ALLOC_RUN, 32'h0, 32'h0);
        send_request(KIND_ALLOC_LARGE, 32'h0, 32'h0);
        send_request(KIND_SPARE_A, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(KIND_SPARE_B, 32'h0, 32'h0);
        send_request(KIND_MARK_FREE, 32'h0, 32'h0);   // zero-size region still retakes page 0
        send_request(KIND_MARK_FREE, 32'h0, 32'h0800_0000);
        send_request(KIND_ALLOC_ONE, 32'h0, 32'h0);   // window 0: no space even with free pages

        // Directed: full window.
        set_managed_blocks(16'd32768);
        send_request(KIND_ALLOC_ONE, 32'h0, 32'h0);
        send_request(KIND_ALLOC_RUN, 32'h0, 32'd0);
        send_request(KIND_ALLOC_RUN, 32'h0, 32'd5);
        send_request(KIND_ALLOC_RUN, 32'h0, 32'hFFFF_FFFF);
        send_request(KIND_ALLOC_LARGE, 32'h0, 32'h0);
        send_request(KIND_MARK_USED, 32'hFFFF_F000, 32'hFFFF_FFFF);  // entirely past the map
        send_request(KIND_FREE_RUN, 32'h0, 32'd1);                    // free run may clear page 0
        send_request(KIND_ALLOC_ONE, 32'h0, 32'h0);                   // page 0 still never granted
        send_request(KIND_MARK_FREE, 32'h07FF_F800, 32'hFFFF_FFFF);   // size near the top
        send_request(KIND_MARK_USED, 32'h0000_1001, 32'd1);
        send_request(KIND_MARK_USED, 32'h0000_1FFF, 32'd2);           // straddles a page boundary
        send_request(KIND_FREE_RUN, 32'h07FF_F000, 32'hFFFF_FFFF);
        send_request(KIND_MARK_USED, 32'h0, 32'h0800_0000);           // everything taken again
        send_request(KIND_ALLOC_LARGE, 32'h0, 32'h0);
        send_request(KIND_MARK_FREE, 32'h0, 32'h0800_0000);

        // Random phases over several windows, extremes included.
        window_sizes[0] = 16'd32768;
        window_sizes[1] = 16'hFFFF;
        window_sizes[2] = 16'd31;
        window_sizes[3] = 16'd1056;
        window_sizes[4] = 16'(3072 + $urandom_range(0, 63));
        window_sizes[5] = 16'($urandom);
        window_sizes[6] = 16'd0;
        window_sizes[7] = 16'd32768;
        for (int ph = 0; ph < 8; ph++) begin
            set_managed_blocks(window_sizes[ph]);
            stall_mode = ph % 4;
            // one long hold-off only in the second phase, after some results exist
            if (ph == 1) squeeze_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) send_random_request();
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
design/bpfa_pkg.sv
design/bpfa_ctrl.sv
design/bpfa_dp.sv
design/bitmap_page_frame_allocator_top.sv
design/bpfa_checker.sv
tb/bpfa_result_checker.sv
tb/bitmap_page_frame_allocator_top_test.sv
